// ===== src/ppc_pkg.sv =====
// Shared types and constants for the polygon point containment block.
package ppc_pkg;

    localparam int DEF_MAX_VERTICES  = 64;
    localparam int DEF_COORD_BITS    = 16;
    localparam int INDEX_BITS        = 6;
    localparam int MODE_BITS         = 2;
    localparam int MIN_POLY_VERTICES = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_SET    = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    // Commands from the controller to the datapath, valid for one cycle.
    typedef struct packed {
        logic wr;           // write the input vertex into the store
        logic box_clear;    // set the bounding box to all zero
        logic box_add;      // widen the box by the input vertex
        logic box_first;    // the added vertex is the only one stored
        logic q_start;      // latch the query point, clear the parity
        logic issue;        // a vertex read (or closing edge) enters the walk
        logic issue_first;  // this entry is vertex zero
        logic issue_close;  // closing edge, uses the saved first vertex
        logic issue_last;   // last entry of the walk
        logic issue_box;    // the walk rebuilds the box instead of counting
        logic res_now;      // deliver a result at once
        logic res_ok;       // accepted flag of that result
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic in_box;       // input point lies in the half-open box
        logic scan_done;    // last walk entry has left the pipeline
    } t_dp_status;

endpackage

// ===== src/ppc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ppc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ppc_ctrl.sv =====
// Controller state machine: vertex count, walk sequencing and immediate results.
module ppc_ctrl #(
    parameter int MAX_VERTICES = ppc_pkg::DEF_MAX_VERTICES,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ppc_pkg::MODE_BITS-1:0]  i_mode,
    input  logic [ppc_pkg::INDEX_BITS-1:0] i_vertex_index,
    input  ppc_pkg::t_dp_status            i_status,
    output logic                           o_busy,
    output ppc_pkg::t_dp_cmd               o_cmd,
    output logic [AW-1:0]                  o_waddr,
    output logic [AW-1:0]                  o_raddr
);

    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CNTW > ppc_pkg::INDEX_BITS) ? CNTW : ppc_pkg::INDEX_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_count, n_count;
    logic [CNTW-1:0]   r_idx, n_idx;
    logic              r_box_scan, n_box_scan;
    logic [CMPW-1:0]   idx_ext;
    logic [CMPW-1:0]   count_ext;

    assign idx_ext   = CMPW'(i_vertex_index);
    assign count_ext = CMPW'(r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_box_scan = r_box_scan;
        o_cmd      = '0;
        o_waddr    = r_count[AW-1:0];
        o_raddr    = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_mode)
                        ppc_pkg::MODE_CLEAR: begin
                            n_count         = '0;
                            o_cmd.box_clear = 1'b1;
                            o_cmd.res_now   = 1'b1;
                            o_cmd.res_ok    = 1'b1;
                        end
                        ppc_pkg::MODE_APPEND: begin
                            o_cmd.res_now = 1'b1;
                            if (r_count < CNTW'(MAX_VERTICES)) begin
                                o_cmd.wr        = 1'b1;
                                o_cmd.box_add   = 1'b1;
                                o_cmd.box_first = (r_count == '0);
                                o_cmd.res_ok    = 1'b1;
                                n_count         = r_count + CNTW'(1);
                            end
                        end
                        ppc_pkg::MODE_SET: begin
                            o_waddr = idx_ext[AW-1:0];
                            if (idx_ext < count_ext) begin
                                // The box is rebuilt from every stored vertex.
                                o_cmd.wr   = 1'b1;
                                n_idx      = '0;
                                n_box_scan = 1'b1;
                                n_state    = S_SCAN;
                            end else begin
                                o_cmd.res_now = 1'b1;
                            end
                        end
                        ppc_pkg::MODE_QUERY: begin
                            if (r_count < CNTW'(ppc_pkg::MIN_POLY_VERTICES) ||
                                !i_status.in_box) begin
                                o_cmd.res_now = 1'b1;
                                o_cmd.res_ok  = 1'b1;
                            end else begin
                                o_cmd.q_start = 1'b1;
                                n_idx         = '0;
                                n_box_scan    = 1'b0;
                                n_state       = S_SCAN;
                            end
                        end
                        default: begin
                            o_cmd.res_now = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.issue     = 1'b1;
                o_cmd.issue_box = r_box_scan;
                if (r_box_scan) begin
                    o_cmd.issue_first = (r_idx == '0);
                    if (r_idx == r_count - CNTW'(1)) begin
                        o_cmd.issue_last = 1'b1;
                        n_state          = S_WAIT;
                    end else begin
                        n_idx = r_idx + CNTW'(1);
                    end
                end else if (r_idx == r_count) begin
                    o_cmd.issue_close = 1'b1;
                    o_cmd.issue_last  = 1'b1;
                    n_state           = S_WAIT;
                end else begin
                    o_cmd.issue_first = (r_idx == '0);
                    n_idx             = r_idx + CNTW'(1);
                end
            end
            S_WAIT: begin
                if (i_status.scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_box_scan <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_box_scan <= n_box_scan;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== src/ppc_dp.sv =====
// Datapath: vertex store, bounding box, edge crossing pipeline and result registers.
module ppc_dp #(
    parameter int MAX_VERTICES = ppc_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = ppc_pkg::DEF_COORD_BITS,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppc_pkg::t_dp_cmd             i_cmd,
    input  logic [AW-1:0]                i_waddr,
    input  logic [AW-1:0]                i_raddr,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    output ppc_pkg::t_dp_status          o_status,
    output logic                         o_done,
    output logic                         o_inside_res,
    output logic                         o_accepted
);

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * (CB + 1);

    logic [2*CB-1:0]        rdata;
    logic signed [CB-1:0]   q_x, q_y, cur_x, cur_y;

    logic signed [CB-1:0]   r_box_left, r_box_top, r_box_right, r_box_bottom;
    logic signed [CB-1:0]   r_px, r_py;
    logic signed [CB-1:0]   r_first_x, r_first_y, r_prev_x, r_prev_y;

    // Stage 1: read data of the store, aligned with its command.
    logic r_s1_valid, r_s1_first, r_s1_close, r_s1_last, r_s1_box;
    // Stage 2: edge operands and range flags.
    logic                 r_s2_valid, r_s2_last, r_s2_cand, r_s2_vert;
    logic signed [CB:0]   r_s2_a, r_s2_b, r_s2_c, r_s2_d;
    // Stage 3: the two cross products.
    logic                 r_s3_valid, r_s3_last, r_s3_cand, r_s3_vert;
    logic signed [PW-1:0] r_p1, r_p2;

    logic r_parity;
    logic r_done, r_inside, r_accepted;

    logic signed [CB-1:0] ymin, ymax, xmax;
    logic signed [CB:0]   px_e, py_e, x1_e, y1_e, x2_e, y2_e, dy;
    logic signed [PW-1:0] p1, p2;
    logic                 edge_en, box_last, hit, parity_n;

    ppc_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (i_waddr),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_raddr (i_raddr),
        .o_rdata (rdata)
    );

    assign q_x   = rdata[2*CB-1:CB];
    assign q_y   = rdata[CB-1:0];
    assign cur_x = r_s1_close ? r_first_x : q_x;
    assign cur_y = r_s1_close ? r_first_y : q_y;

    assign o_status.in_box = (i_coord_x >= r_box_left) && (i_coord_x < r_box_right) &&
                             (i_coord_y >= r_box_top) && (i_coord_y < r_box_bottom);

    // Edge from the previous vertex to the current one.
    always_comb begin
        ymin = (r_prev_y < cur_y) ? r_prev_y : cur_y;
        ymax = (r_prev_y < cur_y) ? cur_y : r_prev_y;
        xmax = (r_prev_x < cur_x) ? cur_x : r_prev_x;
        px_e = {r_px[CB-1], r_px};
        py_e = {r_py[CB-1], r_py};
        x1_e = {r_prev_x[CB-1], r_prev_x};
        y1_e = {r_prev_y[CB-1], r_prev_y};
        x2_e = {cur_x[CB-1], cur_x};
        y2_e = {cur_y[CB-1], cur_y};
        dy   = y2_e - y1_e;
    end

    assign edge_en  = r_s1_valid && !r_s1_box && !r_s1_first;
    assign box_last = r_s1_valid && r_s1_box && r_s1_last;

    assign p1 = r_s2_a * r_s2_b;
    assign p2 = r_s2_c * r_s2_d;

    assign hit      = r_s3_valid && r_s3_cand && (r_s3_vert || (r_p1 <= r_p2));
    assign parity_n = r_parity ^ hit;

    assign o_status.scan_done = box_last || (r_s3_valid && r_s3_last);

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_parity   <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= edge_en;
            r_s3_valid <= r_s2_valid;
            if (i_cmd.q_start) begin
                r_parity <= 1'b0;
            end else begin
                r_parity <= parity_n;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.issue_first;
        r_s1_close <= i_cmd.issue_close;
        r_s1_last  <= i_cmd.issue_last;
        r_s1_box   <= i_cmd.issue_box;
        if (i_cmd.q_start) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (r_s1_valid && !r_s1_box) begin
            if (r_s1_first) begin
                r_first_x <= q_x;
                r_first_y <= q_y;
            end
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
        end
        r_s2_last <= r_s1_last;
        r_s2_cand <= (r_py > ymin) && (r_py <= ymax) && (r_px <= xmax) &&
                     (r_prev_y != cur_y);
        r_s2_vert <= (r_prev_x == cur_x);
        r_s2_a    <= px_e - x1_e;
        r_s2_b    <= dy[CB] ? -dy : dy;
        r_s2_c    <= dy[CB] ? (y1_e - py_e) : (py_e - y1_e);
        r_s2_d    <= x2_e - x1_e;
        r_s3_last <= r_s2_last;
        r_s3_cand <= r_s2_cand;
        r_s3_vert <= r_s2_vert;
        r_p1      <= p1;
        r_p2      <= p2;
    end

    // Bounding box.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left   <= '0;
            r_box_top    <= '0;
            r_box_right  <= '0;
            r_box_bottom <= '0;
        end else if (i_cmd.box_clear) begin
            r_box_left   <= '0;
            r_box_top    <= '0;
            r_box_right  <= '0;
            r_box_bottom <= '0;
        end else if (i_cmd.box_add) begin
            if (i_cmd.box_first || i_coord_x < r_box_left) r_box_left <= i_coord_x;
            if (i_cmd.box_first || i_coord_x > r_box_right) r_box_right <= i_coord_x;
            if (i_cmd.box_first || i_coord_y < r_box_top) r_box_top <= i_coord_y;
            if (i_cmd.box_first || i_coord_y > r_box_bottom) r_box_bottom <= i_coord_y;
        end else if (r_s1_valid && r_s1_box) begin
            if (r_s1_first || q_x < r_box_left) r_box_left <= q_x;
            if (r_s1_first || q_x > r_box_right) r_box_right <= q_x;
            if (r_s1_first || q_y < r_box_top) r_box_top <= q_y;
            if (r_s1_first || q_y > r_box_bottom) r_box_bottom <= q_y;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= 1'b0;
            r_inside   <= 1'b0;
            r_accepted <= 1'b0;
        end else if (i_cmd.res_now) begin
            r_done     <= 1'b1;
            r_inside   <= 1'b0;
            r_accepted <= i_cmd.res_ok;
        end else if (box_last) begin
            r_done     <= 1'b1;
            r_inside   <= 1'b0;
            r_accepted <= 1'b1;
        end else if (r_s3_valid && r_s3_last) begin
            r_done     <= 1'b1;
            r_inside   <= parity_n;
            r_accepted <= 1'b1;
        end else begin
            r_done     <= 1'b0;
            r_inside   <= 1'b0;
            r_accepted <= 1'b0;
        end
    end

    assign o_done       = r_done;
    assign o_inside_res = r_inside;
    assign o_accepted   = r_accepted;

endmodule

// ===== src/polygon_point_containment.sv =====
// Top level of the polygon point containment block: controller, datapath and checks.
//
// The block keeps a polygon of up to MAX_VERTICES signed vertices and its
// bounding box, and answers whether a point lies inside by even-odd crossing count.
// An item is accepted at a rising edge with start high and busy low. Its mode
// selects clear, append a vertex, overwrite a vertex by index, or query a point.
// Each item yields exactly one result, shown on o_inside_res and o_accepted for a
// single cycle while o_done is high; the receiver cannot stall, so a result is
// taken in the cycle it appears.
// Clear, append, a rejected set and a query answered by the count or box check
// give their result in the cycle after acceptance and leave busy low, so such items
// can follow every cycle.
// A set rewrites the vertex and then rebuilds the box by reading every stored
// vertex, one per cycle from the store's single read port; the result arrives in
// the cycle in which busy drops.
// A full query reads the stored vertices one per cycle, adds the closing edge, and
// runs each edge through a three-stage crossing pipeline with an exact integer
// cross-multiplication; busy stays high until its result arrives, so a new query
// cannot be taken before the last one is answered.
// Reset is synchronous and active low; it empties the polygon and zeroes the box.
// The vertex store itself is not cleared; only written slots are ever used.
module polygon_point_containment #(
    parameter int MAX_VERTICES = ppc_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = ppc_pkg::DEF_COORD_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ppc_pkg::MODE_BITS-1:0]  i_mode,
    input  logic [ppc_pkg::INDEX_BITS-1:0] i_vertex_index,
    input  logic signed [COORD_BITS-1:0]   i_coord_x,
    input  logic signed [COORD_BITS-1:0]   i_coord_y,
    output logic                           o_done,
    output logic                           o_inside_res,
    output logic                           o_accepted
);

    localparam int AW = $clog2(MAX_VERTICES);

    ppc_pkg::t_dp_cmd    cmd;
    ppc_pkg::t_dp_status status;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;

    // The controller sequences every item and owns the vertex count.
    ppc_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_mode         (i_mode),
        .i_vertex_index (i_vertex_index),
        .i_status       (status),
        .o_busy         (busy),
        .o_cmd          (cmd),
        .o_waddr        (waddr),
        .o_raddr        (raddr)
    );

    // The datapath holds the store, the box, the crossing pipeline and the result.
    ppc_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS),
        .AW           (AW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_waddr      (waddr),
        .i_raddr      (raddr),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .o_status     (status),
        .o_done       (o_done),
        .o_inside_res (o_inside_res),
        .o_accepted   (o_accepted)
    );

    // The store is only written by an item accepted in that same cycle.
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr |-> (start && !busy))
        else $error("vertex store written without an accepted item");

    // A walk can only finish while the block is busy with it.
    a_scan_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.scan_done |-> busy)
        else $error("walk finished while idle");

    // An inside answer is always a delivered, accepted result.
    a_inside_is_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_inside_res |-> (o_done && o_accepted))
        else $error("inside flag outside a result");

    // A clear item is answered in the next cycle as accepted and not inside.
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == ppc_pkg::MODE_CLEAR) |=>
        (o_done && o_accepted && !o_inside_res))
        else $error("clear item not answered in the next cycle");

endmodule
